// ----- hdl/glb_pkg.sv -----
// Shared types, constants and codes of the greedy line breaker and aligner.
`default_nettype none

package glb_pkg;

  // Field widths of the fixed point words and counters.
  localparam int unsigned WidthBits  = 22;
  localparam int unsigned CountBits  = 12;
  localparam int unsigned IndentBits = 23;
  localparam int unsigned ModeBits   = 3;
  localparam int unsigned CfgIdxBits = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CfgSpaceWidth = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgLineLimit  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgAlignMode  = 2'd2;

  // Alignment mode codes.
  localparam logic [ModeBits-1:0] ModeNone    = 3'd0;
  localparam logic [ModeBits-1:0] ModeLeft    = 3'd1;
  localparam logic [ModeBits-1:0] ModeRight   = 3'd2;
  localparam logic [ModeBits-1:0] ModeJustify = 3'd3;
  localparam logic [ModeBits-1:0] ModeCenter  = 3'd4;

  // One input word.
  typedef struct packed {
    logic [WidthBits-1:0] word_len;
    logic                 paragraph_end;
  } in_t;

  // One emitted line.
  typedef struct packed {
    logic signed [IndentBits-1:0] indent;
    logic [WidthBits-1:0]         gap;
    logic [CountBits-1:0]         words_in_line;
    logic                         final_line;
    logic                         run_last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic div_start;
    logic load_out;
    logic emit_final;
    logic clear_line;
    logic add_word;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic brk;
    logic pend;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- hdl/glb_div.sv -----
// Bit-serial restoring divider for the justify spacing.
`default_nettype none

module glb_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [glb_pkg::WidthBits-1:0] dividend_i,
  input  wire logic [glb_pkg::CountBits-1:0] divisor_i,
  output logic      [glb_pkg::WidthBits-1:0] quotient_o,
  output logic                               done_o
);
  import glb_pkg::*;

  localparam int unsigned CntBits = $clog2(WidthBits);
  localparam logic [CntBits-1:0] LastStep = CntBits'(WidthBits - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [CountBits-1:0] rem_q, rem_d;
  logic [WidthBits-1:0] quo_q, quo_d;
  logic [CountBits-1:0] dvs_q, dvs_d;
  logic [CountBits:0]   shifted;
  logic [CountBits:0]   diff;
  logic                 fits;

  // One quotient bit per cycle: shift in the next dividend bit, try to subtract.
  // The partial remainder stays below the divisor, so it fits the count width.
  assign shifted = {rem_q, quo_q[WidthBits-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[CountBits-1:0] : shifted[CountBits-1:0];
      quo_d = {quo_q[WidthBits-2:0], fits};
      cnt_d = cnt_q + CntBits'(1);
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control flags reset; the arithmetic registers need none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

// ----- hdl/glb_datapath.sv -----
// Datapath: configuration, line state, alignment arithmetic and output register.
`default_nettype none

module glb_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [glb_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [glb_pkg::WidthBits-1:0]  cfg_data_i,
  input  wire glb_pkg::in_t                   in_data_i,
  input  wire glb_pkg::ctrl_cmd_t             cmd_i,
  output glb_pkg::dp_sts_t                    sts_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output glb_pkg::out_t                       out_data_o
);
  import glb_pkg::*;

  localparam logic [WidthBits-1:0] WidthMax = {WidthBits{1'b1}};
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  logic [WidthBits-1:0] space_q, limit_q;
  logic [ModeBits-1:0]  mode_q;
  logic [WidthBits-1:0] width_q, width_d;
  logic [CountBits-1:0] words_q, words_d;
  logic [WidthBits-1:0] word_q;
  logic                 pend_q;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q;
  out_t                 line;

  logic [WidthBits+1:0]         sum;
  logic [ModeBits-1:0]          mode_eff;
  logic signed [IndentBits-1:0] slack, slack_adj, center;
  logic                         slack_neg;
  logic [WidthBits-1:0]         slack_abs;
  logic [WidthBits+1:0]         quo_ext;
  logic signed [WidthBits+1:0]  quo_s, gsum;
  logic [WidthBits-1:0]         gap_sat;
  logic [WidthBits-1:0]         quotient;
  logic                         div_done;
  logic                         out_xfer;

  // Configuration registers; to be written only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_q <= '0;
      limit_q <= '0;
      mode_q  <= ModeNone;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSpaceWidth: space_q <= cfg_data_i;
        CfgLineLimit:  limit_q <= cfg_data_i;
        CfgAlignMode:  mode_q  <= cfg_data_i[ModeBits-1:0];
        default: ;
      endcase
    end
  end

  // Input word holding register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      word_q <= in_data_i.word_len;
      pend_q <= in_data_i.paragraph_end;
    end
  end

  // Width of the line if the pending word joined it, before saturation.
  assign sum = {2'b00, width_q} + {2'b00, space_q} + {2'b00, word_q};

  // Line state: add the word with saturation, or clear after a line is emitted.
  always_comb begin
    width_d = width_q;
    words_d = words_q;
    if (cmd_i.clear_line) begin
      width_d = '0;
      words_d = '0;
    end else if (cmd_i.add_word) begin
      if (words_q == '0) begin
        width_d = word_q;
      end else begin
        width_d = (sum > {2'b00, WidthMax}) ? WidthMax : sum[WidthBits-1:0];
      end
      if (words_q != CountMax) begin
        words_d = words_q + CountBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= '0;
      words_q <= '0;
    end else begin
      width_q <= width_d;
      words_q <= words_d;
    end
  end

  // Slack of the current line and its magnitude for the divider.
  assign slack     = $signed({1'b0, limit_q}) - $signed({1'b0, width_q});
  assign slack_neg = slack[IndentBits-1];
  assign slack_abs = slack_neg ? WidthBits'(-slack) : slack[WidthBits-1:0];

  glb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (slack_abs),
    .divisor_i  (words_q - CountBits'(1)),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // Half the slack, truncated toward zero.
  assign slack_adj = slack + $signed({{(IndentBits-1){1'b0}}, slack_neg});
  assign center    = slack_adj >>> 1;

  // Justified gap: space plus signed quotient, clamped to the field range.
  assign quo_ext = {2'b00, quotient};
  assign quo_s   = slack_neg ? -$signed(quo_ext) : $signed(quo_ext);
  assign gsum    = $signed({2'b00, space_q}) + quo_s;

  always_comb begin
    if (gsum[WidthBits+1]) begin
      gap_sat = '0;
    end else if (gsum[WidthBits]) begin
      gap_sat = WidthMax;
    end else begin
      gap_sat = gsum[WidthBits-1:0];
    end
  end

  // Unused mode codes behave as left.
  assign mode_eff = (mode_q > ModeCenter) ? ModeLeft : mode_q;

  // Assemble the emitted line from the current state.
  always_comb begin
    line.indent        = '0;
    line.gap           = space_q;
    line.words_in_line = words_q;
    line.final_line    = cmd_i.emit_final;
    line.run_last      = cmd_i.emit_final | ~pend_q;
    unique case (mode_eff)
      ModeRight:  line.indent = slack;
      ModeCenter: line.indent = center;
      ModeJustify: begin
        if (!cmd_i.emit_final) begin
          line.gap = (words_q > CountBits'(1)) ? gap_sat : '0;
        end
      end
      default: ;
    endcase
  end

  // Output register: a result waits here while the receiver stalls.
  assign out_xfer = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_xfer) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= line;
    end
  end

  // Status for the controller.
  always_comb begin
    sts_o.brk      = (mode_q != ModeNone) && (words_q != '0) && (sum > {2'b00, limit_q});
    sts_o.pend     = pend_q;
    sts_o.div_done = div_done;
    sts_o.out_free = ~out_valid_q | out_xfer;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An emitted line always holds at least one word.
  a_words_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.words_in_line != '0))
    else $error("emitted line with zero words");

  // A loaded result is presented in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- hdl/glb_ctrl.sv -----
// Controller state machine that sequences break, add, divide and emit.
`default_nettype none

module glb_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire glb_pkg::dp_sts_t sts_i,
  output glb_pkg::ctrl_cmd_t    cmd_o
);
  import glb_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_ADD    = 3'd2;
  localparam logic [2:0] S_FINAL  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       final_q, final_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    final_d = final_q;
    cmd_o   = '0;
    cmd_o.emit_final = final_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.brk) begin
          cmd_o.div_start = 1'b1;
          final_d         = 1'b0;
          state_d         = S_DIV;
        end else begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add_word = 1'b1;
        state_d        = sts_i.pend ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        cmd_o.div_start = 1'b1;
        final_d         = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.clear_line = 1'b1;
          state_d          = final_q ? S_IDLE : S_ADD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // A result is loaded only into a free output register.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("result loaded over a waiting result");

  // After an input transfer the block is busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again without processing");

  // The divider finishes only while the controller waits for it.
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

// ----- hdl/greedy_line_breaker_aligner.sv -----
// Top level of the greedy line breaker and aligner.
//
// Words enter on the input channel (in_valid_i / in_stall_o, payload in_data_i)
// as fixed point widths with a paragraph end flag. Lines leave on the output
// channel (out_valid_o / out_stall_i, payload out_data_o) with indent, gap,
// word count, a final line flag and a flag on the last line caused by a word.
// A transfer happens at a clock edge where valid is high and stall is low.
// Registers are written through cfg_valid_i / cfg_ready_o with cfg_index_i
// and cfg_data_i; cfg_ready_o is always high, and writes must go in only
// while idle, which the block does not enforce. Words are processed one at
// a time. Each emitted line passes through the bit-serial divider that forms
// the justify spacing over 22 quotient bits and is then loaded into the
// output register. A word that breaks the line first emits the line before
// it, and a word that ends its paragraph then emits its final line.
// A finished line waits in the output register while the receiver stalls;
// the next word is taken meanwhile, and the block holds only when a second
// line is ready while the first still waits. Reset clears the registers,
// the line state and any pending result.
`default_nettype none

module greedy_line_breaker_aligner (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [glb_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [glb_pkg::WidthBits-1:0]  cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire glb_pkg::in_t                   in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output glb_pkg::out_t                       out_data_o
);
  import glb_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready_o = 1'b1;

  glb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  glb_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- bench/glb_line_checker.sv -----
// Line checker for the greedy line breaker and aligner: predicts every emitted line and compares.
module glb_line_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [glb_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [glb_pkg::WidthBits-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  glb_pkg::in_t                   in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  glb_pkg::out_t                  out_data_i,
  output int                             fail_count_o,
  output int                             lines_pending_o
);
  import glb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [WidthBits-1:0] WidthMax = '1;
  localparam logic [CountBits-1:0] CountMax = '1;

  // Shadow copy of the registers and of the line being built.
  logic [WidthBits-1:0] space_q;
  logic [WidthBits-1:0] limit_q;
  logic [ModeBits-1:0]  mode_q;
  logic [WidthBits-1:0] line_width_q;
  logic [CountBits-1:0] line_words_q;

  // Lines predicted but not yet seen on the output channel, oldest first.
  out_t due_lines[$];
  int   fails;

  // Indent and spacing of the current line under the current registers.
  function automatic out_t layout_line(input logic last);
    logic [ModeBits-1:0] mode;
    longint              lim;
    longint              wid;
    longint              slack;
    longint              spacing;
    longint              split;
    out_t                line;
    mode  = (mode_q > ModeCenter) ? ModeLeft : mode_q;
    lim   = limit_q;
    wid   = line_width_q;
    slack = lim - wid;
    line.indent        = '0;
    line.gap           = space_q;
    line.words_in_line = line_words_q;
    line.final_line    = last;
    line.run_last      = 1'b0;
    case (mode)
      ModeRight: begin
        line.indent = slack[IndentBits-1:0];
      end
      ModeCenter: begin
        spacing     = slack / 2;
        line.indent = spacing[IndentBits-1:0];
      end
      ModeJustify: begin
        // The last line of a paragraph is set flush left instead.
        if (!last) begin
          if (line_words_q > 1) begin
            split   = line_words_q - 1;
            spacing = space_q;
            spacing = spacing + slack / split;
            if (spacing < 0) spacing = 0;
            if (spacing > longint'(WidthMax)) spacing = longint'(WidthMax);
            line.gap = spacing[WidthBits-1:0];
          end else begin
            line.gap = '0;
          end
        end
      end
      default: ;
    endcase
    return line;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [WidthBits-1:0] w;
    logic [WidthBits+1:0] total;
    logic                 brk;
    out_t                 brk_line;
    out_t                 fin_line;
    out_t                 want;
    if (!rst_ni) begin
      space_q      = '0;
      limit_q      = '0;
      mode_q       = ModeNone;
      line_width_q = '0;
      line_words_q = '0;
      due_lines.delete();
      fails        = 0;
      fail_count_o    <= 0;
      lines_pending_o <= 0;
    end else begin
      // A register write takes effect before a word taken at the same edge.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgSpaceWidth: space_q = cfg_data_i;
          CfgLineLimit:  limit_q = cfg_data_i;
          CfgAlignMode:  mode_q  = cfg_data_i[ModeBits-1:0];
          default: ;
        endcase
      end

      // Word transfer: maybe close the line, add the word, maybe end the paragraph.
      if (in_valid_i && !in_stall_i) begin
        w     = in_data_i.word_len;
        total = line_width_q + space_q + w;
        brk   = (mode_q != ModeNone) && (line_words_q != 0) && (total > limit_q);
        if (brk) begin
          brk_line     = layout_line(1'b0);
          line_width_q = '0;
          line_words_q = '0;
        end
        if (line_words_q == 0) begin
          line_width_q = w;
        end else begin
          total        = line_width_q + space_q + w;
          line_width_q = (total > WidthMax) ? WidthMax : total[WidthBits-1:0];
        end
        if (line_words_q != CountMax) line_words_q = line_words_q + 1'b1;
        if (in_data_i.paragraph_end) begin
          fin_line     = layout_line(1'b1);
          line_width_q = '0;
          line_words_q = '0;
        end
        if (brk) begin
          brk_line.run_last = !in_data_i.paragraph_end;
          due_lines.insert(due_lines.size(), brk_line);
        end
        if (in_data_i.paragraph_end) begin
          fin_line.run_last = 1'b1;
          due_lines.insert(due_lines.size(), fin_line);
        end
      end

      // Line transfer: compare field by field with the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (due_lines.size() == 0) begin
          $error("line transfer with no line expected: words_in_line %0d",
                 out_data_i.words_in_line);
          fails++;
        end else begin
          want = due_lines.pop_front();
          if (out_data_i.indent !== want.indent) begin
            $error("indent: expected %0d, got %0d", want.indent, out_data_i.indent);
            fails++;
          end
          if (out_data_i.gap !== want.gap) begin
            $error("gap: expected %0d, got %0d", want.gap, out_data_i.gap);
            fails++;
          end
          if (out_data_i.words_in_line !== want.words_in_line) begin
            $error("words_in_line: expected %0d, got %0d", want.words_in_line,
                   out_data_i.words_in_line);
            fails++;
          end
          if (out_data_i.final_line !== want.final_line) begin
            $error("final_line: expected %0d, got %0d", want.final_line,
                   out_data_i.final_line);
            fails++;
          end
          if (out_data_i.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, out_data_i.run_last);
            fails++;
          end
        end
      end

      fail_count_o    <= fails;
      lines_pending_o <= due_lines.size();
    end
  end

endmodule

// ----- bench/greedy_line_breaker_aligner_test.sv -----
// Top of the line breaker test: clock, reset, register writes, word stimulus and verdict.
module greedy_line_breaker_aligner_test;
  import glb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [WidthBits-1:0]  WidthMax    = '1;
  localparam logic [CfgIdxBits-1:0] CfgUnused   = 2'd3;
  localparam int                    HoldCycles  = 400;
  localparam int                    DrainCycles = 80;
  localparam int                    SegWords    = 36;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [WidthBits-1:0]  cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;

  int fail_count;
  int lines_pending;

  // Idle rates of the two sides, in percent of cycles.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Long receiver hold-off, requested by the stimulus and counted below.
  bit hold_req  = 1'b0;
  int hold_left = 0;

  // Current paragraph width, used to size random words.
  logic [WidthBits-1:0] cur_limit = '0;

  always #5 clk = ~clk;

  greedy_line_breaker_aligner dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  glb_line_checker line_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .fail_count_o    (fail_count),
    .lines_pending_o (lines_pending)
  );

  // Output stall: random idling, or a long hold-off while one is requested.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // One register write transfer, then the valid drops for a cycle.
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [WidthBits-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all three registers; the mode write carries random upper bits.
  task automatic set_regs(input logic [WidthBits-1:0] space, input logic [WidthBits-1:0] limit,
                          input logic [ModeBits-1:0] mode);
    logic [31:0] rnd;
    rnd = $urandom();
    write_reg(CfgSpaceWidth, space);
    write_reg(CfgLineLimit, limit);
    write_reg(CfgAlignMode, {rnd[WidthBits-1:ModeBits], mode});
    cur_limit = limit;
  endtask

  // Offers one word, with random idle cycles first, until its transfer.
  task automatic send_word(input logic [WidthBits-1:0] w, input logic pend);
    in_t item;
    item.word_len      = w;
    item.paragraph_end = pend;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering words and waits until every predicted line has left the block.
  task automatic wait_idle;
    in_valid <= 1'b0;
    do @(posedge clk); while (lines_pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Mostly words that fit a few to a line, sometimes extremes or full-range values.
  task automatic send_random_word;
    int unsigned          pick;
    int unsigned          span;
    logic [31:0]          rnd;
    logic [WidthBits-1:0] w;
    pick = $urandom_range(19, 0);
    span = (cur_limit / 3) + 64;
    rnd  = $urandom();
    case (pick)
      0:       w = rnd[WidthBits-1:0];
      1:       w = '0;
      2:       w = WidthMax;
      default: w = WidthBits'($urandom_range(span, 0));
    endcase
    send_word(w, $urandom_range(7, 0) == 0);
  endtask

  // Random register setting, extremes and unused mode codes included.
  task automatic random_regs;
    int unsigned          pick;
    logic [31:0]          rnd;
    logic [WidthBits-1:0] space;
    logic [WidthBits-1:0] limit;
    logic [ModeBits-1:0]  mode;
    pick = $urandom_range(9, 0);
    if (pick == 0) begin
      space = $urandom_range(1, 0) ? WidthMax : '0;
      limit = $urandom_range(1, 0) ? WidthMax : '0;
    end else if (pick == 1) begin
      rnd   = $urandom();
      space = rnd[WidthBits-1:0];
      rnd   = $urandom();
      limit = rnd[WidthBits-1:0];
    end else begin
      space = WidthBits'($urandom_range(256, 0));
      limit = WidthBits'($urandom_range(8192, 256));
    end
    pick = $urandom_range(11, 0);
    mode = (pick < 10) ? ModeBits'(pick % 5) : ModeBits'($urandom_range(7, 5));
    set_regs(space, limit, mode);
  endtask

  initial begin
    send_idle_pct = 7;
    recv_idle_pct = 61;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at reset: mode none, zero space, so the paragraph is one line.
    send_word('0, 1'b0);
    send_word(WidthMax, 1'b0);
    send_word(22'd5, 1'b1);
    wait_idle;
    write_reg(CfgUnused, WidthMax);

    // Left: a break, a word wider than the limit, then a break and a final line.
    set_regs(22'd64, 22'd1280, ModeLeft);
    send_word(22'd320, 1'b0);
    send_word(22'd640, 1'b0);
    send_word(22'd640, 1'b0);
    send_word(WidthMax, 1'b0);
    send_word(22'd100, 1'b1);

    // Right and center, with an odd slack and a negative one.
    wait_idle;
    write_reg(CfgAlignMode, WidthBits'(ModeRight));
    send_word(22'd300, 1'b0);
    send_word(22'd400, 1'b1);
    wait_idle;
    write_reg(CfgAlignMode, WidthBits'(ModeCenter));
    send_word(22'd300, 1'b0);
    send_word(22'd301, 1'b1);
    send_word(22'd2000, 1'b1);

    // Justify: widened spacing, flush left at paragraph end, single-word lines.
    wait_idle;
    write_reg(CfgAlignMode, WidthBits'(ModeJustify));
    send_word(22'd300, 1'b0);
    send_word(22'd300, 1'b0);
    send_word(22'd300, 1'b0);
    send_word(22'd500, 1'b0);
    send_word(22'd100, 1'b1);
    send_word(22'd700, 1'b1);
    send_word(22'd1000, 1'b0);
    send_word(22'd1000, 1'b0);
    send_word(22'd10, 1'b0);

    // Limit lowered in mid line: negative slack, the spacing clamps at zero.
    wait_idle;
    write_reg(CfgLineLimit, '0);
    send_word(22'd5, 1'b0);
    wait_idle;
    write_reg(CfgLineLimit, WidthMax);
    write_reg(CfgSpaceWidth, '0);
    send_word(22'd10, 1'b0);

    // Huge space in mid line: the spacing clamps at its top.
    wait_idle;
    write_reg(CfgSpaceWidth, WidthMax);
    send_word(22'd1, 1'b1);

    // An unused mode code behaves as left.
    wait_idle;
    set_regs(22'd64, 22'd1280, ModeBits'(5));
    send_word(22'd300, 1'b0);
    send_word(22'd1200, 1'b1);

    // Mode none lets the width saturate; the break under right uses it.
    wait_idle;
    set_regs(22'd64, 22'd1000, ModeNone);
    send_word(WidthMax, 1'b0);
    send_word(22'd3000, 1'b0);
    wait_idle;
    write_reg(CfgAlignMode, WidthBits'(ModeRight));
    send_word(22'd10, 1'b1);

    // A long line under mode none, then a justify break that divides by its word count less one.
    wait_idle;
    send_idle_pct = 0;
    set_regs('0, WidthMax, ModeNone);
    repeat (40) send_word(22'd500, 1'b0);
    wait_idle;
    set_regs(22'd64, WidthMax, ModeJustify);
    send_word(WidthMax, 1'b0);
    send_word(22'd7, 1'b1);

    // Random part in three idling phases, several settings in each.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        wait_idle;
        if (phase == 2 && seg == 0) begin
          // Narrow lines under a long hold-off, so the block fills and stalls.
          set_regs(22'd64, 22'd200, ModeJustify);
          hold_req = 1'b1;
        end else begin
          random_regs;
        end
        repeat (SegWords) send_random_word;
      end
    end

    wait_idle;
    if (fail_count == 0 && lines_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
